/* rtl/ppa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppa_pkg: shared types and constants of the physical page allocator
// Field widths, status codes, request codes and configuration register indexes.
// ----------------------------------------------------------------------------
package ppa_pkg;

    localparam int ADDR_W        = 32;  // byte address width
    localparam int PAGE_SHIFT    = 12;  // 4 KiB pages
    localparam int ADDR_IDX_W    = ADDR_W - PAGE_SHIFT;
    localparam int REG_W         = 14;  // configuration register width
    localparam int USED_W        = 14;  // used page counter width
    localparam int CNT_W         = 8;   // reference count width
    localparam int STATUS_W      = 3;
    localparam int CFG_IDX_W     = 2;
    localparam int NUM_PAGES_DEF = 8192;

    localparam logic [REG_W-1:0] FIRST_PAGE_RST = REG_W'(256);
    localparam logic [REG_W-1:0] PAGE_COUNT_RST = REG_W'(8192);

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_PAGE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT = CFG_IDX_W'(1);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_NOMEM  = 3'd1,
        ST_ALIGN  = 3'd2,
        ST_RANGE  = 3'd3,
        ST_UNUSED = 3'd4
    } t_status;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

endpackage

/* rtl/ppa_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppa_req_if: request channel of the page allocator
// Valid/ready handshake carrying the action and the page address.
// ----------------------------------------------------------------------------
interface ppa_req_if;
    import ppa_pkg::*;

    logic              valid;
    logic              ready;
    t_action           action;
    logic [ADDR_W-1:0] page_address;

    modport source (output valid, output action, output page_address, input ready);
    modport sink   (input valid, input action, input page_address, output ready);
endinterface

/* rtl/ppa_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppa_rsp_if: response channel of the page allocator
// Valid/ready handshake carrying the granted address, status and page usage.
// ----------------------------------------------------------------------------
interface ppa_rsp_if;
    import ppa_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] granted_address;
    t_status           status;
    logic              became_free;
    logic [USED_W-1:0] pages_in_use;

    modport source (output valid, output granted_address, output status,
                    output became_free, output pages_in_use, input ready);
    modport sink   (input valid, input granted_address, input status,
                    input became_free, input pages_in_use, output ready);
endinterface

/* rtl/ppa_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppa_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ppa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/physical_page_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// physical_page_allocator: first-fit page frame allocator with ref counts
// Reference counts live in one RAM; a small sequencer scans, checks and
// updates them and returns one response per request.
// ----------------------------------------------------------------------------
// Usage: after reset the block zeroes the count RAM, one entry per cycle, with
// the request ready low (config writes are taken). An allocate request reads
// the RAM one page per cycle from first_page up to min(page_count, NUM_PAGES)
// and stops at the first zero count; the single RAM read port sets that pace.
// A free request reads the count, writes it back and hands over the response;
// when the address check fails it goes straight to the response instead.
// One request is in flight at a time; its response sits in an output register
// so the next request can be taken while that response waits to be accepted.
// Config registers must only be written while no request is outstanding.
// ----------------------------------------------------------------------------
module physical_page_allocator
    import ppa_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ppa_req_if.sink              i_req,
    ppa_rsp_if.source            o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]     i_cfg_data
);

    // page index width and a compare width wide enough for the limit,
    // the config registers and a page number taken from a byte address
    localparam int IW = $clog2(NUM_PAGES);
    localparam int CW = (IW + 1 > ADDR_IDX_W) ? IW + 1 : ADDR_IDX_W;

    typedef enum logic [2:0] {
        S_CLEAR,    // zeroing pass after reset
        S_IDLE,     // ready for a request
        S_SCAN,     // first-fit search
        S_FREE_RD,  // count read for a free
        S_EMIT      // hand result to output register
    } t_state;

    t_state            r_state, n_state;
    logic [REG_W-1:0]  r_first_page, n_first_page;
    logic [REG_W-1:0]  r_page_count, n_page_count;
    logic [CW-1:0]     r_addr, n_addr;       // scan / clear pointer
    logic              r_pend, n_pend;       // a scan read is in flight
    logic [IW-1:0]     r_idx, n_idx;         // page whose count is arriving
    logic [USED_W-1:0] r_used, n_used;
    logic [ADDR_W-1:0] r_res_granted, n_res_granted;
    t_status           r_res_status, n_res_status;
    logic              r_res_freed, n_res_freed;
    logic              r_rsp_valid, n_rsp_valid;
    logic [ADDR_W-1:0] r_rsp_granted, n_rsp_granted;
    t_status           r_rsp_status, n_rsp_status;
    logic              r_rsp_freed, n_rsp_freed;
    logic [USED_W-1:0] r_rsp_used, n_rsp_used;

    // RAM port
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [CNT_W-1:0]  ram_wdata;
    logic [IW-1:0]     ram_raddr;
    logic [CNT_W-1:0]  ram_rdata;

    logic [CW-1:0]     w_limit;
    logic [CW-1:0]     w_first;
    logic [CW-1:0]     w_req_page;
    logic              w_req_accept;
    logic              w_misaligned;
    logic              w_out_of_range;
    logic              w_out_free;

    ppa_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_PAGES)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // managed range is [first_page, min(page_count, NUM_PAGES))
    assign w_first = CW'(r_first_page);
    assign w_limit = (CW'(r_page_count) < CW'(NUM_PAGES)) ? CW'(r_page_count)
                                                          : CW'(NUM_PAGES);

    assign w_req_page     = CW'(i_req.page_address[ADDR_W-1:PAGE_SHIFT]);
    assign w_misaligned   = |i_req.page_address[PAGE_SHIFT-1:0];
    assign w_out_of_range = (w_req_page < w_first) || (w_req_page >= w_limit);

    assign i_req.ready  = (r_state == S_IDLE);
    assign w_req_accept = i_req.valid && i_req.ready;
    assign w_out_free   = !r_rsp_valid || o_rsp.ready;

    always_comb begin
        n_state       = r_state;
        n_first_page  = r_first_page;
        n_page_count  = r_page_count;
        n_addr        = r_addr;
        n_pend        = r_pend;
        n_idx         = r_idx;
        n_used        = r_used;
        n_res_granted = r_res_granted;
        n_res_status  = r_res_status;
        n_res_freed   = r_res_freed;
        n_rsp_valid   = r_rsp_valid && !o_rsp.ready;
        n_rsp_granted = r_rsp_granted;
        n_rsp_status  = r_rsp_status;
        n_rsp_freed   = r_rsp_freed;
        n_rsp_used    = r_rsp_used;
        ram_we        = 1'b0;
        ram_waddr     = r_idx;
        ram_wdata     = '0;
        ram_raddr     = r_addr[IW-1:0];

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FIRST_PAGE: n_first_page = i_cfg_data;
                REG_PAGE_COUNT: n_page_count = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr[IW-1:0];
                n_addr    = r_addr + 1'b1;
                if (r_addr[IW-1:0] == IW'(NUM_PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                ram_raddr = w_req_page[IW-1:0];
                if (w_req_accept) begin
                    n_res_granted = '0;
                    n_res_freed   = 1'b0;
                    n_res_status  = ST_OK;
                    n_idx         = w_req_page[IW-1:0];
                    if (i_req.action == ACT_ALLOC) begin
                        n_addr = w_first;
                        n_pend = 1'b0;
                        if (w_first >= w_limit) begin
                            n_res_status = ST_NOMEM;
                            n_state      = S_EMIT;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else if (w_misaligned) begin
                        n_res_status = ST_ALIGN;
                        n_state      = S_EMIT;
                    end else if (w_out_of_range) begin
                        n_res_status = ST_RANGE;
                        n_state      = S_EMIT;
                    end else begin
                        n_state = S_FREE_RD;
                    end
                end
            end
            S_SCAN: begin
                if (r_pend && (ram_rdata == '0)) begin
                    // free page found: claim it
                    ram_we        = 1'b1;
                    ram_wdata     = CNT_W'(1);
                    n_used        = (r_used == '1) ? r_used : r_used + 1'b1;
                    n_res_granted = ADDR_W'(r_idx) << PAGE_SHIFT;
                    n_state       = S_EMIT;
                end else if (r_addr < w_limit) begin
                    n_pend = 1'b1;
                    n_idx  = r_addr[IW-1:0];
                    n_addr = r_addr + 1'b1;
                end else begin
                    n_res_status = ST_NOMEM;
                    n_state      = S_EMIT;
                end
            end
            S_FREE_RD: begin
                if (ram_rdata == '0) begin
                    n_res_status = ST_UNUSED;
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata - 1'b1;
                    if (ram_rdata == CNT_W'(1)) begin
                        n_res_freed = 1'b1;
                        n_used      = (r_used == '0) ? r_used : r_used - 1'b1;
                    end
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_rsp_valid   = 1'b1;
                    n_rsp_granted = r_res_granted;
                    n_rsp_status  = r_res_status;
                    n_rsp_freed   = r_res_freed;
                    n_rsp_used    = r_used;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_first_page <= FIRST_PAGE_RST;
            r_page_count <= PAGE_COUNT_RST;
            r_addr       <= '0;
            r_pend       <= 1'b0;
            r_used       <= '0;
            r_rsp_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_first_page <= n_first_page;
            r_page_count <= n_page_count;
            r_addr       <= n_addr;
            r_pend       <= n_pend;
            r_used       <= n_used;
            r_rsp_valid  <= n_rsp_valid;
        end
        r_idx         <= n_idx;
        r_res_granted <= n_res_granted;
        r_res_status  <= n_res_status;
        r_res_freed   <= n_res_freed;
        r_rsp_granted <= n_rsp_granted;
        r_rsp_status  <= n_rsp_status;
        r_rsp_freed   <= n_rsp_freed;
        r_rsp_used    <= n_rsp_used;
    end

    assign o_rsp.valid           = r_rsp_valid;
    assign o_rsp.granted_address = r_rsp_granted;
    assign o_rsp.status          = r_rsp_status;
    assign o_rsp.became_free     = r_rsp_freed;
    assign o_rsp.pages_in_use    = r_rsp_used;

`ifndef SYNTHESIS
    // no RAM write while waiting for a request or handing off a result
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_EMIT) |-> !ram_we)
        else $error("count RAM written outside an active request");

    // the page counter only moves while a request is being worked on
    a_used_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_EMIT || r_state == S_CLEAR)
            |=> $stable(r_used))
        else $error("used page count changed without a request");

    // a page can only become free on a successful free
    a_freed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.became_free)
            |-> (o_rsp.status == ST_OK && o_rsp.granted_address == '0))
        else $error("became_free on a failed request or an allocation");

    // failed requests return no address
    a_err_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK)
            |-> (o_rsp.granted_address == '0 && !o_rsp.became_free))
        else $error("error response carries an address or a free flag");
`endif

endmodule
